// ===== sv/egcd_pkg.sv =====
package egcd_pkg;

  // fixed widths of the result fields
  localparam int COEF_W = 64;
  localparam int GCD_W  = 63;

  // per-cycle status from the shared divider
  typedef struct packed {
    logic qbit_vld;
    logic qbit;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/extended_gcd.sv =====
// Extended Euclid: a transaction is taken when start is high while busy is low;
// the block then stays busy until its result is out. Each Euclid step is a test
// state, a pass through the shared one-bit-per-cycle restoring divider and an
// update state; with 64-bit operands the worst case is 91 steps (consecutive
// fibonacci magnitudes given smaller first). The result appears for exactly
// one cycle with out_valid high and the receiver cannot stall it, so it must
// be captured then. Only the low OPERAND_WIDTH bits of each operand are used,
// read as two's complement.
module extended_gcd #(
  parameter int OPERAND_WIDTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [63:0]                in_a_value,
  input  logic signed [63:0]                in_b_value,
  output logic                              out_valid,
  output logic [egcd_pkg::GCD_W-1:0]        out_gcd_value,
  output logic signed [egcd_pkg::COEF_W-1:0] out_coef_s,
  output logic signed [egcd_pkg::COEF_W-1:0] out_coef_t
);
  import egcd_pkg::*;

  localparam int W = OPERAND_WIDTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE
  } state_t;

  state_t             state_r;
  logic [W-1:0]       u_r;
  logic [W-1:0]       v_r;
  logic               aneg_r;
  logic               bneg_r;
  logic [COEF_W-1:0]  sa_r, ta_r, sb_r, tb_r;
  logic [COEF_W-1:0]  ps_r, pt_r;
  logic               out_valid_r;
  logic [GCD_W-1:0]   out_gcd_r;
  logic [COEF_W-1:0]  out_s_r, out_t_r;

  logic [W-1:0]       a_w, b_w, a_mag, b_mag;
  logic [COEF_W-1:0]  u_ext;
  logic               div_start;
  div_stat_t          div_stat;
  logic [W-1:0]       div_rem;

  // operand magnitudes, most negative value comes out exact as unsigned
  assign a_w   = in_a_value[W-1:0];
  assign b_w   = in_b_value[W-1:0];
  assign a_mag = a_w[W-1] ? (~a_w + W'(1)) : a_w;
  assign b_mag = b_w[W-1] ? (~b_w + W'(1)) : b_w;
  assign u_ext = COEF_W'(u_r);

  assign div_start = (state_r == ST_CHECK) && (v_r != '0);

  egcd_div #(
    .W (W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (u_r),
    .divisor   (v_r),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  // sequencer: test, divide with running q*coef products, update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            u_r     <= a_mag;
            v_r     <= b_mag;
            aneg_r  <= a_w[W-1];
            bneg_r  <= b_w[W-1];
            sa_r    <= COEF_W'(1);
            ta_r    <= '0;
            sb_r    <= '0;
            tb_r    <= COEF_W'(1);
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (v_r == '0) begin
            out_gcd_r   <= u_ext[GCD_W-1:0];
            out_s_r     <= aneg_r ? (~sa_r + COEF_W'(1)) : sa_r;
            out_t_r     <= bneg_r ? (~ta_r + COEF_W'(1)) : ta_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else begin
            ps_r    <= '0;
            pt_r    <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          // horner accumulation of q*sb and q*tb, quotient msb first
          if (div_stat.qbit_vld) begin
            ps_r <= {ps_r[COEF_W-2:0], 1'b0} + (div_stat.qbit ? sb_r : '0);
            pt_r <= {pt_r[COEF_W-2:0], 1'b0} + (div_stat.qbit ? tb_r : '0);
          end
          if (div_stat.done) begin
            state_r <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          u_r     <= v_r;
          v_r     <= div_rem;
          sa_r    <= sb_r;
          ta_r    <= tb_r;
          sb_r    <= sa_r - ps_r;
          tb_r    <= ta_r - pt_r;
          state_r <= ST_CHECK;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_gcd_value = out_gcd_r;
  assign out_coef_s    = out_s_r;
  assign out_coef_t    = out_t_r;

endmodule

// ===== sv/egcd_div.sv =====
module egcd_div #(
  parameter int W = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [W-1:0]          dividend,
  input  logic [W-1:0]          divisor,
  output egcd_pkg::div_stat_t   stat,
  output logic [W-1:0]          remainder
);
  import egcd_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r;
  logic [W-1:0]  dvd_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          qbit;

  // one restoring step: shift in next dividend bit, trial subtract
  assign trial = {rem_r, dvd_r[W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign qbit  = ~diff[W];

  // quotient bits come out msb first, one per cycle
  assign stat.qbit_vld = run_r;
  assign stat.qbit     = qbit;
  assign stat.done     = run_r && (cnt_r == CW'(1));
  assign remainder     = rem_r;

  // control of the bit loop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= CW'(W);
    end else if (run_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_r <= 1'b0;
      end
    end
  end

  // partial remainder and dividend shifter
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
    end else if (run_r) begin
      rem_r <= qbit ? diff[W-1:0] : trial[W-1:0];
      dvd_r <= {dvd_r[W-2:0], 1'b0};
    end
  end

endmodule
